// ----- hw/rtl/thseq_pkg.sv -----
// Shared types and constants for the table homing sequencer.
`timescale 1ns / 1ps
`default_nettype none

package thseq_pkg;

  // Sequencer phases. Codes five to seven never occur in normal operation.
  typedef enum logic [2:0] {
    PH_SEEK_MOTOR_END = 3'd0,
    PH_SEEK_ENC_END   = 3'd1,
    PH_SEEK_PE        = 3'd2,
    PH_BACKOFF        = 3'd3,
    PH_FINISH         = 3'd4
  } phase_t;

  localparam int unsigned BACKOFF_W = 17;
  localparam int unsigned COUNT_W   = 16;

  // Configuration register indexes.
  typedef enum logic {
    CFG_SENSOR_OFF_LEVEL = 1'b0,
    CFG_STEP_BACK_COUNT  = 1'b1
  } cfg_index_t;

  localparam logic [COUNT_W-1:0] STEP_BACK_RESET = 16'd100;

  // One result item.
  typedef struct packed {
    logic homing_active;
    logic ready_res;
    logic pe_out;
    logic step_direction;
    logic motor_step;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/table_homing_sequencer.sv -----
// Top level of the table homing sequencer: phase sequencer, back-off counter, result register.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted input request is one tick of the homing sequence. The block
// takes one request per clock cycle and presents its result in the next cycle
// from a result register; the only loop is the phase and back-off counter
// update, which completes in the accepting cycle, so the sustained rate is one
// request per cycle whenever the output side is ready. in_tready drops only
// while a finished result waits in the result register and the downstream
// side is stalling. A homing run steps + toward the motor-side end, - toward
// the encoder-side end, + toward the PE sensor, then step_back_count+1 steps
// back, and finishes in the finish phase that follows by setting ready_res. Before that,
// pe_out mirrors manual_pe; afterwards it is derived from the PE and
// motor-side end sensors. Configuration writes are always accepted and are
// expected only while no request is in flight.
module table_homing_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input stream.
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // Bits from 0: start_homing, restart, motor_end_level, encoder_end_level,
  // paper_end_level, manual_pe, two zero pad bits.
  input  wire logic [7:0]                  in_tdata,
  // Result stream.
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // Bits from 0: motor_step, step_direction, pe_out, ready_res,
  // homing_active, three zero pad bits.
  output logic [7:0]                       out_tdata,
  // Configuration write channel.
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire thseq_pkg::cfg_index_t       cfg_index,
  input  wire logic [15:0]                 cfg_data
);
  import thseq_pkg::*;

  // Configuration registers.
  logic               sensor_off_level_r;
  logic [COUNT_W-1:0] step_back_count_r;

  // Sequencer state.
  phase_t               phase_r, phase_nxt;
  logic [BACKOFF_W-1:0] backoff_r, backoff_nxt;
  logic                 run_req_r, run_req_nxt;
  logic                 homed_r, homed_nxt;

  // Result register.
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic in_accept;
  logic start_homing, restart, motor_end_level, encoder_end_level;
  logic paper_end_level, manual_pe;
  logic run_eff;
  phase_t phase_eff;
  logic motor_off, enc_off, pe_off;
  logic backoff_more;

  assign start_homing      = in_tdata[0];
  assign restart           = in_tdata[1];
  assign motor_end_level   = in_tdata[2];
  assign encoder_end_level = in_tdata[3];
  assign paper_end_level   = in_tdata[4];
  assign manual_pe         = in_tdata[5];

  // The result register frees up when it is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // A start request latches before sequencing, and restart rewinds the phase
  // before the phase logic looks at it.
  assign run_eff   = run_req_r || start_homing;
  assign phase_eff = restart ? PH_SEEK_MOTOR_END : phase_r;

  assign motor_off    = (motor_end_level == sensor_off_level_r);
  assign enc_off      = (encoder_end_level == sensor_off_level_r);
  assign pe_off       = (paper_end_level == sensor_off_level_r);
  assign backoff_more = (backoff_r <= {1'b0, step_back_count_r});

  // Next-state logic.
  always_comb begin
    phase_nxt   = phase_eff;
    backoff_nxt = backoff_r;
    run_req_nxt = run_eff;
    homed_nxt   = homed_r;
    if (run_eff) begin
      case (phase_eff)
        PH_SEEK_MOTOR_END: begin
          if (!motor_off) phase_nxt = PH_SEEK_ENC_END;
        end
        PH_SEEK_ENC_END: begin
          if (!enc_off) phase_nxt = PH_SEEK_PE;
        end
        PH_SEEK_PE: begin
          if (!pe_off) phase_nxt = PH_BACKOFF;
        end
        PH_BACKOFF: begin
          if (backoff_more) begin
            backoff_nxt = backoff_r + BACKOFF_W'(1);
          end else begin
            backoff_nxt = '0;
            phase_nxt   = PH_FINISH;
          end
        end
        PH_FINISH: begin
          phase_nxt   = PH_SEEK_MOTOR_END;
          run_req_nxt = 1'b0;
          homed_nxt   = 1'b1;
        end
        default: begin
          phase_nxt = PH_SEEK_MOTOR_END;
        end
      endcase
    end
  end

  // Output logic for the tick being accepted.
  always_comb begin
    res_nxt = '0;
    if (run_eff) begin
      case (phase_eff)
        PH_SEEK_MOTOR_END: begin
          res_nxt.motor_step     = motor_off;
          res_nxt.step_direction = motor_off;
        end
        PH_SEEK_ENC_END: begin
          res_nxt.motor_step = enc_off;
        end
        PH_SEEK_PE: begin
          res_nxt.motor_step     = pe_off;
          res_nxt.step_direction = pe_off;
        end
        PH_BACKOFF: begin
          res_nxt.motor_step = backoff_more;
        end
        default: begin
          res_nxt.motor_step = 1'b0;
        end
      endcase
    end
    // Once homed, PE reads high when the PE sensor is off, else it follows
    // whether the motor-side end is triggered.
    if (homed_nxt) begin
      res_nxt.pe_out = pe_off || !motor_off;
    end else begin
      res_nxt.pe_out = manual_pe;
    end
    res_nxt.ready_res     = homed_nxt;
    res_nxt.homing_active = run_req_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_off_level_r <= 1'b0;
      step_back_count_r  <= STEP_BACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SENSOR_OFF_LEVEL: sensor_off_level_r <= cfg_data[0];
        CFG_STEP_BACK_COUNT:  step_back_count_r  <= cfg_data;
        default:              sensor_off_level_r <= sensor_off_level_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SEEK_MOTOR_END;
      backoff_r <= '0;
      run_req_r <= 1'b0;
      homed_r   <= 1'b0;
    end else if (in_accept) begin
      phase_r   <= phase_nxt;
      backoff_r <= backoff_nxt;
      run_req_r <= run_req_nxt;
      homed_r   <= homed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.homing_active, res_r.ready_res, res_r.pe_out,
                       res_r.step_direction, res_r.motor_step};

  // Homed is sticky until reset.
  a_homed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    homed_r |=> homed_r)
    else $error("homed flag cleared without reset");

  // A plus direction is only reported together with a step.
  a_dir_with_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.step_direction) |-> res_r.motor_step)
    else $error("direction set without a step");

  // Finishing a run rewinds the phase and drops the run request together.
  a_finish_clean: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(homed_r) |-> (phase_r == PH_SEEK_MOTOR_END) && !run_req_r)
    else $error("run finished with phase or request left set");

  // A stalled result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_accept)
    else $error("new request accepted over a stalled result");

endmodule

`default_nettype wire

// ----- dv/thseq_checker.sv -----
// Checker for the table homing sequencer: predicts each tick's result and compares it.
`timescale 1ns / 1ps

module thseq_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  thseq_pkg::cfg_index_t cfg_index,
  input  logic [15:0]           cfg_data,
  output int                    fail_count,
  output int                    ticks_pending
);

  import thseq_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the registers and of the sequencer state.
  logic                 off_level;
  logic [COUNT_W-1:0]   back_count;
  phase_t               seq_phase;
  logic [BACKOFF_W-1:0] backoff_done;
  logic                 run_req;
  logic                 homed;

  result_t expected_ticks[$];
  int      failures = 0;

  assign fail_count = failures;

  // Sequences one tick and returns the result it should produce.
  function automatic result_t advance_homing(input logic [5:0] req);
    logic    start_b, restart_b, motor_b, enc_b, pe_b, manual_b;
    result_t r;
    {manual_b, pe_b, enc_b, motor_b, restart_b, start_b} = req;
    r = '0;
    if (start_b) run_req = 1'b1;
    if (restart_b) seq_phase = PH_SEEK_MOTOR_END;
    if (run_req) begin
      case (seq_phase)
        PH_SEEK_MOTOR_END: begin
          if (motor_b == off_level) begin
            r.motor_step     = 1'b1;
            r.step_direction = 1'b1;
          end else begin
            seq_phase = PH_SEEK_ENC_END;
          end
        end
        PH_SEEK_ENC_END: begin
          if (enc_b == off_level) r.motor_step = 1'b1;
          else seq_phase = PH_SEEK_PE;
        end
        PH_SEEK_PE: begin
          if (pe_b == off_level) begin
            r.motor_step     = 1'b1;
            r.step_direction = 1'b1;
          end else begin
            seq_phase = PH_BACKOFF;
          end
        end
        PH_BACKOFF: begin
          // The count survives a restart, so a later back-off resumes from it.
          if (backoff_done <= {1'b0, back_count}) begin
            r.motor_step = 1'b1;
            backoff_done = backoff_done + BACKOFF_W'(1);
          end else begin
            backoff_done = '0;
            seq_phase    = PH_FINISH;
          end
        end
        PH_FINISH: begin
          seq_phase = PH_SEEK_MOTOR_END;
          run_req   = 1'b0;
          homed     = 1'b1;
        end
        default: seq_phase = PH_SEEK_MOTOR_END;
      endcase
    end
    if (homed) r.pe_out = (pe_b == off_level) ? 1'b1 : (motor_b != off_level);
    else r.pe_out = manual_b;
    r.ready_res     = homed;
    r.homing_active = run_req;
    return r;
  endfunction

  function automatic string show_result(input result_t r);
    return $sformatf("step=%b dir=%b pe=%b ready=%b active=%b",
                     r.motor_step, r.step_direction, r.pe_out, r.ready_res, r.homing_active);
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst_n) begin
      off_level    = 1'b0;
      back_count   = STEP_BACK_RESET;
      seq_phase    = PH_SEEK_MOTOR_END;
      backoff_done = '0;
      run_req      = 1'b0;
      homed        = 1'b0;
      expected_ticks.delete();
    end else begin
      // A result leaving now belongs to an earlier request, so compare first.
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[4:0]);
        if (expected_ticks.size() == 0) begin
          failures = failures + 1;
          if (failures <= REPORT_LIMIT)
            $display("%0t: result with none expected: %s", $realtime, show_result(got));
        end else begin
          want = expected_ticks.pop_front();
          if (got !== want || out_tdata[7:5] !== 3'b000) begin
            failures = failures + 1;
            if (failures <= REPORT_LIMIT)
              $display("%0t: result mismatch: expected %s, got %s pad=%b", $realtime,
                       show_result(want), show_result(got), out_tdata[7:5]);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SENSOR_OFF_LEVEL: off_level  = cfg_data[0];
          CFG_STEP_BACK_COUNT:  back_count = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_ticks.push_back(advance_homing(in_tdata[5:0]));
    end
    ticks_pending <= expected_ticks.size();
  end

endmodule

// ----- dv/tb_table_homing_sequencer.sv -----
// Testbench top for the table homing sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_table_homing_sequencer;

  import thseq_pkg::*;

  // Bits of one tick request, from bit 0 up: start_homing, restart,
  // motor_end_level, encoder_end_level, paper_end_level, manual_pe.
  localparam logic [5:0] REQ_NONE      = 6'b000000;
  localparam logic [5:0] REQ_START     = 6'b000001;
  localparam logic [5:0] REQ_RESTART   = 6'b000010;
  localparam logic [5:0] REQ_MOTOR_END = 6'b000100;
  localparam logic [5:0] REQ_ENC_END   = 6'b001000;
  localparam logic [5:0] REQ_PE        = 6'b010000;
  localparam logic [5:0] REQ_MANUAL_PE = 6'b100000;

  // The receiver's long hold must outlast the single result register many
  // times over; the watchdog must outlast every legal gap by a wide margin.
  localparam int LONG_HOLD      = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_RUN_TICKS = 60;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;    // start_homing, restart, motor_end, enc_end, pe, manual_pe
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;   // motor_step, step_direction, pe_out, ready_res, active
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_index_t            cfg_index;
  logic [15:0]           cfg_data;

  int   fail_count;
  int   ticks_pending;
  int   idle_cycles = 0;

  // Shared between stimulus and receiver: quiet turns off all random gaps,
  // hold_ask asks the receiver for one long hold.
  logic quiet;
  logic hold_ask;
  // Raw level that currently means "sensor not triggered".
  logic cur_off;

  // Random phases: sensor polarity, back-off count and number of requests.
  int plan_off   [5] = '{1, 0, 1, 0, 1};
  int plan_count [5] = '{0, 7, 100, 2, 31};
  int plan_items [5] = '{180, 230, 280, 230, 230};

  table_homing_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  thseq_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .ticks_pending (ticks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_cycles();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // A sensor level that is triggered with the given flag, in the current polarity.
  function automatic logic sensor_level(input logic triggered);
    return triggered ? ~cur_off : cur_off;
  endfunction

  // Random tick content. Sensors trigger often enough that a run walks through
  // all of its phases; one tick in ten is plain noise on every bit.
  function automatic logic [5:0] random_tick();
    logic [5:0] req;
    if ($urandom_range(0, 9) == 0) return 6'($urandom);
    req[0] = ($urandom_range(0, 15) == 0);
    req[1] = ($urandom_range(0, 59) == 0);
    req[2] = sensor_level($urandom_range(0, 3) == 0);
    req[3] = sensor_level($urandom_range(0, 3) == 0);
    req[4] = sensor_level($urandom_range(0, 3) == 0);
    req[5] = 1'($urandom_range(0, 1));
    return req;
  endfunction

  // Offers one tick request and returns at the falling edge after its handshake.
  task automatic send_tick(input logic [5:0] req);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_cycles()) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected result has come back; each
  // request yields exactly one result.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (ticks_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // One register write; only called while the block is idle.
  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SENSOR_OFF_LEVEL) cur_off = val[0];
    @(negedge clk);
  endtask

  // Receiver: mostly ready, with random stalls and one long hold on request.
  initial begin : receiver
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_ask) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_ask = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_cycles()) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog: a long stretch with no handshake on any channel is a hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_table_homing_sequencer: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int ph;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SENSOR_OFF_LEVEL;
    cfg_data  = '0;
    quiet     = 1'b0;
    hold_ask  = 1'b0;
    cur_off   = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, with the sensors active high. Before any run completes
    // the PE output simply mirrors the manual level.
    send_tick(REQ_NONE);
    send_tick(REQ_MANUAL_PE);
    // Every bit high: start and restart together, motor end already reached.
    send_tick(6'b111111);
    wait_drained();
    write_reg(CFG_STEP_BACK_COUNT, 16'd1);
    write_reg(CFG_SENSOR_OFF_LEVEL, 16'd0);
    send_tick(REQ_MANUAL_PE);             // step minus toward the encoder end
    send_tick(REQ_ENC_END);               // encoder end reached
    send_tick(REQ_NONE);                  // step plus toward the PE sensor
    send_tick(REQ_PE);                    // PE sensor reached
    send_tick(REQ_MANUAL_PE);             // first back-off step
    // Lowering the count in the middle of back-off ends it on the next tick.
    wait_drained();
    write_reg(CFG_STEP_BACK_COUNT, 16'd0);
    send_tick(REQ_NONE);
    send_tick(REQ_NONE);                  // run finishes, PE sensor off
    send_tick(REQ_PE);                    // homed, PE on and motor end off
    send_tick(REQ_PE | REQ_MOTOR_END);    // homed, PE on and motor end on
    // A second run, restarted during back-off: the back-off count is kept, so
    // the next back-off ends at once.
    send_tick(REQ_START | REQ_MOTOR_END);
    send_tick(REQ_START | REQ_ENC_END);
    send_tick(REQ_PE);
    send_tick(REQ_NONE);
    send_tick(REQ_RESTART);
    send_tick(REQ_MOTOR_END);
    send_tick(REQ_ENC_END);
    send_tick(REQ_PE);
    send_tick(REQ_NONE);
    send_tick(REQ_NONE);

    // One run at the largest back-off count with no gaps; the next register
    // setting lowers the count while that back-off is still under way.
    wait_drained();
    write_reg(CFG_STEP_BACK_COUNT, 16'hFFFF);
    quiet = 1'b1;
    send_tick(REQ_START | REQ_MOTOR_END);
    send_tick(REQ_ENC_END);
    send_tick(REQ_PE);
    for (n = 0; n < LONG_RUN_TICKS; n++)
      send_tick(6'($urandom) & ~(REQ_START | REQ_RESTART));
    quiet = 1'b0;

    // Random phases over several register settings. One phase has no gaps at
    // all, one holds the receiver off while requests keep coming, and one
    // pauses the sender until every result is back.
    for (ph = 0; ph < 5; ph++) begin
      wait_drained();
      write_reg(CFG_SENSOR_OFF_LEVEL, 16'(plan_off[ph]));
      write_reg(CFG_STEP_BACK_COUNT, 16'(plan_count[ph]));
      quiet = (ph == 1);
      for (n = 0; n < plan_items[ph]; n++) begin
        if (ph == 2 && n == 100) hold_ask = 1'b1;
        if (ph == 3 && n == 120) wait_drained();
        send_tick(random_tick());
      end
    end

    wait_drained();
    if (fail_count == 0 && ticks_pending == 0)
      $display("tb_table_homing_sequencer: PASS");
    else
      $display("tb_table_homing_sequencer: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/thseq_pkg.sv
hw/rtl/table_homing_sequencer.sv
dv/thseq_checker.sv
dv/tb_table_homing_sequencer.sv
